@@ rtl/core/timed_pump_drive_controller_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the timed pump drive controller core
// Concurrent checks are compiled in for simulation and left out for synthesis.
// ----------------------------------------------------------------------------
`ifndef TIMED_PUMP_DRIVE_CONTROLLER_CORE_MACROS_SVH
`define TIMED_PUMP_DRIVE_CONTROLLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define TPDC_ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define TPDC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define TPDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TPDC_ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define TPDC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define TPDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/tpdc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpdc_pkg
// Shared types, codes and helpers of the timed pump drive controller core.
// ----------------------------------------------------------------------------
`default_nettype none

package tpdc_pkg;

   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 64;
   localparam int CSR_INDEX_W = 4;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_ID      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_DUTY = 4'd1;

   // Input action codes
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_CMD   = 2'd1;
   localparam logic [1:0] ACT_PULSE = 2'd2;

   // Command codes
   localparam logic [2:0] CMD_START   = 3'd0;
   localparam logic [2:0] CMD_STOP    = 3'd1;
   localparam logic [2:0] CMD_REVERSE = 3'd2;
   localparam logic [2:0] CMD_SPEED   = 3'd3;

   localparam logic [31:0] SPEED_MAX_PCT = 32'd100;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_TICK,
      OP_PULSE,
      OP_START,
      OP_STOP,
      OP_REVERSE,
      OP_SPEED
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic        flush;     // stop with zero payload
      logic [7:0]  duty;      // set speed result
      logic [31:0] payload;   // start duration
   } op_type;

   typedef struct packed {
      logic                   valid;
      logic [CSR_INDEX_W-1:0] index;
      logic [7:0]             data;
   } csr_write_type;

   // floor(pct * 255 / 100) for pct up to 100, by reciprocal 5243 / 2^19
   function automatic logic [7:0] duty_from_percent(input logic [6:0] pct);
      logic [14:0] scaled;
      logic [27:0] prod;
      scaled = {pct, 8'd0} - {8'd0, pct};
      prod   = 28'(scaled) * 28'd5243;
      return prod[26:19];
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/tpdc_front.sv @@
// ----------------------------------------------------------------------------
// tpdc_front
// Decode input items into operations; filter foreign and unknown commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tpdc_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   input  wire logic [1:0]                          req_tuser,
   input  wire logic [tpdc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire tpdc_pkg::csr_write_type             csr_wr,
   output      logic                                op_valid,
   output      tpdc_pkg::op_type                    op
);

   logic [7:0]  node_id_ff;
   logic [7:0]  target_id;
   logic [2:0]  command;
   logic [31:0] payload;
   logic [6:0]  pct;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff <= '0;
      end else if (csr_wr.valid && csr_wr.index == tpdc_pkg::CSR_NODE_ID) begin
         node_id_ff <= csr_wr.data;
      end
   end

   assign target_id = req_tdata[7:0];
   assign command   = req_tdata[10:8];
   assign payload   = req_tdata[42:11];
   assign pct       = (payload > tpdc_pkg::SPEED_MAX_PCT) ? 7'd100 : payload[6:0];

   always_comb begin
      op_valid   = req_tvalid;
      op.kind    = tpdc_pkg::OP_NONE;
      op.flush   = (payload == 32'd0);
      op.duty    = tpdc_pkg::duty_from_percent(pct);
      op.payload = payload;
      case (req_tuser)
         tpdc_pkg::ACT_TICK:  op.kind = tpdc_pkg::OP_TICK;
         tpdc_pkg::ACT_PULSE: op.kind = tpdc_pkg::OP_PULSE;
         tpdc_pkg::ACT_CMD: begin
            if (target_id == node_id_ff) begin
               case (command)
                  tpdc_pkg::CMD_START:   op.kind = tpdc_pkg::OP_START;
                  tpdc_pkg::CMD_STOP:    op.kind = tpdc_pkg::OP_STOP;
                  tpdc_pkg::CMD_REVERSE: op.kind = tpdc_pkg::OP_REVERSE;
                  tpdc_pkg::CMD_SPEED:   op.kind = tpdc_pkg::OP_SPEED;
                  default:               op.kind = tpdc_pkg::OP_NONE;
               endcase
            end
         end
         default: op.kind = tpdc_pkg::OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/tpdc_fifo.sv @@
// ----------------------------------------------------------------------------
// tpdc_fifo
// Two-entry operation queue between the decode front and the execute back.
// ----------------------------------------------------------------------------
`default_nettype none

module tpdc_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire tpdc_pkg::op_type   push_op,
   output      logic               push_ready,
   output      logic               pop_valid,
   output      tpdc_pkg::op_type   pop_op,
   input  wire logic               pop_ready
);

   tpdc_pkg::op_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/tpdc_back.sv @@
// ----------------------------------------------------------------------------
// tpdc_back
// Execute operations on the pump state, hold the duration queue, register
// the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "timed_pump_drive_controller_core_macros.svh"

module tpdc_back #(
   parameter int QUEUE_DEPTH    = 128,
   parameter int COUNT_DELAY_MS = 50
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              op_valid,
   input  wire tpdc_pkg::op_type                  op,
   output      logic                              op_ready,
   input  wire tpdc_pkg::csr_write_type           csr_wr,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [tpdc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   logic [31:0]   dur_mem [QUEUE_DEPTH];

   logic [AW-1:0] head_ff, head_in, head_sel;
   logic [AW-1:0] tail_ff, tail_in;
   logic [FW-1:0] fill_ff, fill_in, fill_sel;
   logic          run_active_ff, run_active_in;
   logic          count_enabled_ff, count_enabled_in;
   logic          swapped_ff, swapped_in;
   logic          speed_given_ff, speed_given_in;
   logic [7:0]    drive_duty_ff, drive_duty_in;
   logic [31:0]   elapsed_ff, elapsed_in, elapsed_inc;
   logic [31:0]   pulse_total_ff, pulse_total_in;
   logic [31:0]   run_length_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [tpdc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic          fire, drop, wr_en, launch, bypass;
   logic [7:0]    duty, pin_a, pin_b, level;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign op_ready = !rsp_valid_ff || rsp_tready;
   assign fire     = op_valid && op_ready;

   always_comb begin
      run_active_in    = run_active_ff;
      count_enabled_in = count_enabled_ff;
      swapped_in       = swapped_ff;
      speed_given_in   = speed_given_ff;
      drive_duty_in    = drive_duty_ff;
      elapsed_in       = elapsed_ff;
      pulse_total_in   = pulse_total_ff;
      head_sel         = head_ff;
      tail_in          = tail_ff;
      fill_sel         = fill_ff;
      drop             = 1'b0;
      wr_en            = 1'b0;
      launch           = 1'b0;
      elapsed_inc      = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 32'd1;

      if (fire) begin
         case (op.kind)
            tpdc_pkg::OP_TICK: begin
               if (run_active_ff) begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= 32'(COUNT_DELAY_MS)) begin
                     count_enabled_in = 1'b1;
                  end
                  if (run_length_ff != '0 && elapsed_inc >= run_length_ff) begin
                     run_active_in = 1'b0;
                  end
               end
            end
            tpdc_pkg::OP_PULSE: begin
               if (count_enabled_ff) begin
                  pulse_total_in = pulse_total_ff + 32'd1;
               end
            end
            tpdc_pkg::OP_START: begin
               if (fill_ff == FW'(QUEUE_DEPTH)) begin
                  drop = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  tail_in  = ptr_next(tail_ff);
                  fill_sel = fill_ff + 1'b1;
               end
            end
            tpdc_pkg::OP_STOP: begin
               if (op.flush) begin
                  fill_sel = '0;
                  head_sel = '0;
                  tail_in  = '0;
               end
               run_active_in    = 1'b0;
               count_enabled_in = 1'b0;
            end
            tpdc_pkg::OP_REVERSE: swapped_in = !swapped_ff;
            tpdc_pkg::OP_SPEED: begin
               drive_duty_in  = op.duty;
               speed_given_in = 1'b1;
            end
            default: ;
         endcase

         // start the oldest waiting run once the pump is idle
         if (!run_active_in && fill_sel != '0) begin
            launch           = 1'b1;
            run_active_in    = 1'b1;
            count_enabled_in = 1'b0;
            elapsed_in       = '0;
            pulse_total_in   = '0;
         end
      end

      if (csr_wr.valid && csr_wr.index == tpdc_pkg::CSR_INITIAL_DUTY && !speed_given_ff) begin
         drive_duty_in = csr_wr.data;
      end

      head_in = launch ? ptr_next(head_sel) : head_sel;
      fill_in = launch ? fill_sel - 1'b1 : fill_sel;
      bypass  = wr_en && (tail_ff == head_sel);

      duty  = run_active_in ? drive_duty_in : 8'd0;
      pin_a = swapped_in ? 8'd0 : duty;
      pin_b = swapped_in ? duty : 8'd0;
      level = (32'(fill_in) > 32'd255) ? 8'd255 : 8'(fill_in);

      rsp_data_in  = {5'd0, drop, level, pulse_total_in, count_enabled_in,
                      run_active_in, pin_b, pin_a};
      rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff          <= '0;
         tail_ff          <= '0;
         fill_ff          <= '0;
         run_active_ff    <= 1'b0;
         count_enabled_ff <= 1'b0;
         swapped_ff       <= 1'b0;
         speed_given_ff   <= 1'b0;
         drive_duty_ff    <= '0;
         elapsed_ff       <= '0;
         pulse_total_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         head_ff          <= head_in;
         tail_ff          <= tail_in;
         fill_ff          <= fill_in;
         run_active_ff    <= run_active_in;
         count_enabled_ff <= count_enabled_in;
         swapped_ff       <= swapped_in;
         speed_given_ff   <= speed_given_in;
         drive_duty_ff    <= drive_duty_in;
         elapsed_ff       <= elapsed_in;
         pulse_total_ff   <= pulse_total_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // duration store: one write at the tail, one registered read at the head
   always_ff @(posedge clock) begin
      if (wr_en) begin
         dur_mem[tail_ff] <= op.payload;
      end
      if (launch) begin
         run_length_ff <= bypass ? op.payload : dur_mem[head_sel];
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `TPDC_ASSERT_HOLDS(a_fill_bound, clock, reset, fill_ff <= FW'(QUEUE_DEPTH), "queue fill beyond depth")
   `TPDC_ASSERT_HOLDS(a_no_idle_backlog, clock, reset, run_active_ff || (fill_ff == '0), "pump idle with durations waiting")
   `TPDC_ASSERT_IMPLIES(a_empty_ptrs, clock, reset, fill_ff == '0, head_ff == tail_ff, "empty queue with split pointers")
   `TPDC_ASSERT_NEXT(a_launch_state, clock, reset, launch, run_active_ff && !count_enabled_ff && (pulse_total_ff == '0), "run start left stale state")

endmodule

`default_nettype wire

@@ rtl/core/timed_pump_drive_controller_core.sv @@
// ----------------------------------------------------------------------------
// timed_pump_drive_controller_core
// Pump driver: timed run queue, direction and speed control, flow counting.
//
//   channel  dir  handshake               payload
//   req      in   req_tvalid/req_tready   tuser action, tdata command fields
//   rsp      out  rsp_tvalid/rsp_tready   tdata drive outputs and status
//   csr      in   csr_valid/csr_ready     csr_index, csr_data
//
// One item is executed per cycle while the output is not stalled; an accepted
// item passes through the operation queue before its result is registered.
// The execute stage updates all pump state at once, which sets the sustained
// rate of one item per clock when rsp_tready does not hold the flow.
// A two-entry operation queue and the output register absorb output stalls.
// Reset is synchronous; the duration store needs no clearing pass since only
// written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_pump_drive_controller_core #(
   parameter int QUEUE_DEPTH    = 128,   // waiting run durations, 1..1024
   parameter int COUNT_DELAY_MS = 50     // settling ticks before flow counting
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input item
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // [1:0] action
   input  wire logic [1:0]                          req_tuser,
   // [7:0] target_id, [10:8] command, [42:11] payload, zeros above
   input  wire logic [tpdc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // result item
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] pin_a_duty, [15:8] pin_b_duty, [16] running, [17] counting,
   // [49:18] flow_count, [57:50] queue_level, [58] dropped, zeros above
   output      logic [tpdc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // configuration writes
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [tpdc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [7:0]                          csr_data
);

   tpdc_pkg::csr_write_type csr_wr;
   tpdc_pkg::op_type        front_op, back_op;
   logic                    front_valid;
   logic                    back_valid, back_ready;

   // configuration is always taken; writes must happen only while idle, which the block does not enforce
   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   // classify the transaction and drop foreign commands to no-ops
   tpdc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_wr     (csr_wr),
      .op_valid   (front_valid),
      .op         (front_op)
   );

   // decouple decode from execution
   tpdc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_op    (front_op),
      .push_ready (req_tready),
      .pop_valid  (back_valid),
      .pop_op     (back_op),
      .pop_ready  (back_ready)
   );

   // carry out the operation and hold the result until taken
   tpdc_back #(
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .COUNT_DELAY_MS (COUNT_DELAY_MS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (back_valid),
      .op         (back_op),
      .op_ready   (back_ready),
      .csr_wr     (csr_wr),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

@@ tb/timed_pump_drive_controller_core_tb.sv @@
// ----------------------------------------------------------------------------
// timed_pump_drive_controller_core_tb
// Self-checking bench for the pump drive controller core. Plain tasks drive
// ticks, commands and flow pulses on the request stream. A small scoreboard
// predicts the drive and status word for every accepted transaction and
// compares each returned word field by field. The bench varies the device
// identifier and the initial duty between phases, and applies idle patterns
// on both streams and long back-pressure on the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_pump_drive_controller_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH    = 128;
   localparam int COUNT_DELAY_MS = 50;
   localparam int SETTLE_CYCLES  = 6;
   localparam int CYCLE_LIMIT    = 200000;

   localparam logic [1:0] ACT_IGNORED = 2'd3;
   localparam logic [2:0] CMD_UNUSED  = 3'd7;

   // Result word as it leaves on rsp_tdata, lowest field last
   typedef struct packed {
      logic [4:0]  spare;
      logic        dropped;
      logic [7:0]  queue_level;
      logic [31:0] flow_count;
      logic        counting;
      logic        running;
      logic [7:0]  pin_b_duty;
      logic [7:0]  pin_a_duty;
   } pump_status_type;

   // -------------------------------------------------------------------------
   // Scoreboard: pump state model and queue of status words still due
   // -------------------------------------------------------------------------
   class pump_scoreboard;
      logic [7:0]   node_id;
      logic [7:0]   initial_duty;
      logic [31:0]  duration_store [QUEUE_DEPTH];
      int unsigned  head;
      int unsigned  fill;
      bit           run_on;
      bit           count_on;
      bit           swapped;
      bit           speed_set;
      logic [7:0]   duty;
      logic [31:0]  run_ms;
      logic [31:0]  elapsed;
      logic [31:0]  pulses;
      pump_status_type status_due[$];
      int unsigned  errors;

      function new();
         node_id      = '0;
         initial_duty = '0;
         head         = 0;
         fill         = 0;
         run_on       = 0;
         count_on     = 0;
         swapped      = 0;
         speed_set    = 0;
         duty         = '0;
         run_ms       = '0;
         elapsed      = '0;
         pulses       = '0;
         errors       = 0;
      endfunction

      function void write_register(logic [tpdc_pkg::CSR_INDEX_W-1:0] index,
                                   logic [7:0] value);
         if (index == tpdc_pkg::CSR_NODE_ID) begin
            node_id = value;
         end else if (index == tpdc_pkg::CSR_INITIAL_DUTY) begin
            initial_duty = value;
            // the power-on duty follows the register until a speed is obeyed
            if (!speed_set) duty = value;
         end
      endfunction

      // Advance the pump state by one accepted transaction and queue its status
      function void predict_status(logic [1:0] action, logic [7:0] target,
                                   logic [2:0] code, logic [31:0] payload);
         pump_status_type st;
         bit           drop;
         logic [31:0]  pct;
         logic [7:0]   live_duty;
         drop = 0;
         case (action)
            tpdc_pkg::ACT_TICK: if (run_on) begin
               if (elapsed != '1) elapsed++;
               if (elapsed >= COUNT_DELAY_MS) count_on = 1;
               if (run_ms != 0 && elapsed >= run_ms) run_on = 0;
            end
            tpdc_pkg::ACT_CMD: if (target == node_id) begin
               case (code)
                  tpdc_pkg::CMD_START: begin
                     if (fill >= QUEUE_DEPTH) begin
                        drop = 1;
                     end else begin
                        duration_store[(head + fill) % QUEUE_DEPTH] = payload;
                        fill++;
                     end
                  end
                  tpdc_pkg::CMD_STOP: begin
                     if (payload == 0) begin
                        fill = 0;
                        head = 0;
                     end
                     run_on   = 0;
                     count_on = 0;
                  end
                  tpdc_pkg::CMD_REVERSE: swapped = !swapped;
                  tpdc_pkg::CMD_SPEED: begin
                     pct       = (payload > tpdc_pkg::SPEED_MAX_PCT) ?
                                 tpdc_pkg::SPEED_MAX_PCT : payload;
                     duty      = 8'((pct * 255) / tpdc_pkg::SPEED_MAX_PCT);
                     speed_set = 1;
                  end
                  default: ;
               endcase
            end
            tpdc_pkg::ACT_PULSE: if (count_on) pulses++;
            default: ;
         endcase
         // an idle pump takes the oldest waiting duration at once
         if (!run_on && fill > 0) begin
            run_ms   = duration_store[head];
            head     = (head + 1) % QUEUE_DEPTH;
            fill--;
            elapsed  = '0;
            pulses   = '0;
            count_on = 0;
            run_on   = 1;
         end
         live_duty      = run_on ? duty : 8'd0;
         st             = '0;
         st.pin_a_duty  = swapped ? 8'd0 : live_duty;
         st.pin_b_duty  = swapped ? live_duty : 8'd0;
         st.running     = run_on;
         st.counting    = count_on;
         st.flow_count  = pulses;
         st.queue_level = (fill > 255) ? 8'd255 : 8'(fill);
         st.dropped     = drop;
         status_due.push_back(st);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      endtask

      task check_status(logic [tpdc_pkg::RSP_DATA_W-1:0] data);
         pump_status_type got;
         pump_status_type want;
         got = pump_status_type'(data);
         if (status_due.size() == 0) begin
            report_mismatch("unexpected result, word", data[31:0], 32'd0);
            return;
         end
         want = status_due.pop_front();
         if (got.pin_a_duty != want.pin_a_duty)
            report_mismatch("pin_a_duty", 32'(got.pin_a_duty), 32'(want.pin_a_duty));
         if (got.pin_b_duty != want.pin_b_duty)
            report_mismatch("pin_b_duty", 32'(got.pin_b_duty), 32'(want.pin_b_duty));
         if (got.running != want.running)
            report_mismatch("running", 32'(got.running), 32'(want.running));
         if (got.counting != want.counting)
            report_mismatch("counting", 32'(got.counting), 32'(want.counting));
         if (got.flow_count != want.flow_count)
            report_mismatch("flow_count", got.flow_count, want.flow_count);
         if (got.queue_level != want.queue_level)
            report_mismatch("queue_level", 32'(got.queue_level), 32'(want.queue_level));
         if (got.dropped != want.dropped)
            report_mismatch("dropped", 32'(got.dropped), 32'(want.dropped));
         if (got.spare !== 5'd0)
            report_mismatch("upper tdata bits", 32'(got.spare), 32'd0);
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [1:0]                       req_tuser;    // [1:0] action
   // [7:0] target_id, [10:8] command, [42:11] payload
   logic [tpdc_pkg::REQ_DATA_W-1:0]  req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   // [7:0] pin_a_duty, [15:8] pin_b_duty, [16] running, [17] counting,
   // [49:18] flow_count, [57:50] queue_level, [58] dropped
   logic [tpdc_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [tpdc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [7:0]                       csr_data;

   timed_pump_drive_controller_core #(
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .COUNT_DELAY_MS (COUNT_DELAY_MS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   pump_scoreboard sb = new();

   int          send_idle_pct = 0;   // chance per cycle that the request side holds back
   int          recv_idle_pct = 0;   // chance per cycle that the result side holds back
   int          stall_cycles  = 0;   // length of the next long result-side hold
   int          stall_seq     = 0;   // bumped by the sender to ask for a hold
   int          items_done;          // transactions this phase that the block acts on
   logic [7:0]  cur_dev;             // device identifier currently programmed
   int unsigned cycle_count = 0;

   always #10 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed_pump_drive_controller_core_tb NOT OK");
         $finish;
      end
   end

   // Result side: drive ready at the falling edge, honour long holds
   initial begin
      int hold_left;
      int seen_seq;
      hold_left  = 0;
      seen_seq   = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_seq != seen_seq) begin
            hold_left = stall_cycles;
            seen_seq  = stall_seq;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Check every returned status word at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_status(rsp_tdata);
   end

   // -------------------------------------------------------------------------
   // Driving tasks; each starts and ends at a falling edge
   // -------------------------------------------------------------------------
   task automatic configure(logic [7:0] dev, logic [7:0] idle_duty);
      for (int i = 0; i < 2; i++) begin
         csr_valid <= 1'b1;
         csr_index <= (i == 0) ? tpdc_pkg::CSR_NODE_ID : tpdc_pkg::CSR_INITIAL_DUTY;
         csr_data  <= (i == 0) ? dev : idle_duty;
         do @(posedge clock); while (!csr_ready);
         sb.write_register(csr_index, csr_data);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      cur_dev = dev;
      @(negedge clock);
   endtask

   task automatic issue(logic [1:0] action, logic [7:0] target, logic [2:0] code,
                        logic [31:0] payload);
      // random gaps before the transaction
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {5'd0, payload, code, target};
      do @(posedge clock); while (!req_tready);
      sb.predict_status(action, target, code, payload);
      if (!(action == ACT_IGNORED ||
            (action == tpdc_pkg::ACT_CMD &&
             (target != cur_dev || code > tpdc_pkg::CMD_SPEED))))
         items_done++;
      @(negedge clock);
   endtask

   task automatic command(logic [2:0] code, logic [31:0] payload);
      issue(tpdc_pkg::ACT_CMD, cur_dev, code, payload);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   // Hold until every status word is back, then let the pipeline settle
   task automatic wait_for_results();
      while (sb.status_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // One timed, endless or long run with ticks, flow pulses and interleaved commands
   task automatic drive_timed_run();
      int          r;
      int          ticks;
      logic [31:0] dur;
      r = $urandom_range(99);
      if (r < 55)      dur = $urandom_range(1, 120);
      else if (r < 70) dur = 32'd0;
      else if (r < 85) dur = $urandom_range(COUNT_DELAY_MS - 5, COUNT_DELAY_MS + 5);
      else             dur = $urandom;
      command(tpdc_pkg::CMD_START, dur);
      ticks = $urandom_range(1, 140);
      repeat (ticks) begin
         r = $urandom_range(99);
         if (r < 30)      issue(tpdc_pkg::ACT_PULSE, 8'($urandom), 3'($urandom), $urandom);
         else if (r < 33) command(tpdc_pkg::CMD_SPEED, $urandom_range(0, 120));
         else if (r < 35) command(tpdc_pkg::CMD_REVERSE, $urandom);
         else if (r < 37) command(tpdc_pkg::CMD_START, $urandom_range(0, 80));
         else             issue(tpdc_pkg::ACT_TICK, 8'($urandom), 3'($urandom), $urandom);
      end
      if ($urandom_range(2) == 0)
         command(tpdc_pkg::CMD_STOP, $urandom_range(1) ? 32'd0 : $urandom);
   endtask

   // Pile starts behind an endless run until the duration queue overflows, then flush
   task automatic overflow_queue();
      command(tpdc_pkg::CMD_START, 32'd0);
      repeat (QUEUE_DEPTH + 3) command(tpdc_pkg::CMD_START, $urandom);
      command(tpdc_pkg::CMD_STOP, 32'd0);
   endtask

   task automatic random_phase(int goal, bit pause_mid, int hold_cycles);
      int r;
      int burst_at;
      bit burst_done;
      bit mid_done;
      items_done = 0;
      burst_done = 0;
      mid_done   = 0;
      burst_at   = $urandom_range(0, goal / 2);
      while (items_done < goal) begin
         if (!burst_done && items_done >= burst_at) begin
            burst_done = 1;
            if (hold_cycles > 0) begin
               stall_cycles = hold_cycles;
               stall_seq++;
            end
            overflow_queue();
         end
         if (!mid_done && items_done >= goal / 2) begin
            mid_done = 1;
            if (pause_mid) begin
               stop_sending();
               wait_for_results();
            end
         end
         r = $urandom_range(99);
         if (r < 60) begin
            drive_timed_run();
         end else if (r < 82) begin
            r = $urandom_range(tpdc_pkg::CMD_START, tpdc_pkg::CMD_SPEED);
            command(3'(r), (r == tpdc_pkg::CMD_SPEED) ? $urandom_range(0, 200) :
                           (r == tpdc_pkg::CMD_START) ? $urandom_range(0, 100) :
                           ($urandom_range(1) ? 32'd0 : $urandom));
         end else if (r < 90) begin
            // foreign identifier: one bit off the programmed one
            issue(tpdc_pkg::ACT_CMD, cur_dev ^ (8'd1 << $urandom_range(7)),
                  3'($urandom), $urandom);
         end else begin
            issue(2'($urandom_range(3)), 8'($urandom), 3'($urandom), $urandom);
         end
      end
      stop_sending();
      wait_for_results();
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      cur_dev    = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: power-on duty at full scale, lowest identifier
      configure(8'h00, 8'hFF);
      issue(tpdc_pkg::ACT_TICK, 8'h00, tpdc_pkg::CMD_START, 32'd0);  // tick while idle
      issue(tpdc_pkg::ACT_PULSE, 8'hFF, CMD_UNUSED, '1);   // pulse while not counting
      issue(ACT_IGNORED, 8'h00, tpdc_pkg::CMD_START, 32'd9);  // unused action
      issue(tpdc_pkg::ACT_CMD, 8'h01, tpdc_pkg::CMD_START, 32'd5);  // foreign identifier
      command(CMD_UNUSED, '1);                            // unused command code
      command(tpdc_pkg::CMD_REVERSE, 32'd0);              // reverse while idle
      command(tpdc_pkg::CMD_START, 32'd2);                // run on the power-on duty
      command(tpdc_pkg::CMD_START, 32'd0);                // endless run waits
      issue(tpdc_pkg::ACT_TICK, 8'hFF, CMD_UNUSED, '1);
      // timed run ends, endless starts
      issue(tpdc_pkg::ACT_TICK, 8'h00, tpdc_pkg::CMD_START, 32'd0);
      command(tpdc_pkg::CMD_SPEED, '1);                   // clamp to full speed
      command(tpdc_pkg::CMD_SPEED, 32'd0);
      command(tpdc_pkg::CMD_SPEED, 32'd37);
      command(tpdc_pkg::CMD_SPEED, 32'd101);
      command(tpdc_pkg::CMD_REVERSE, '1);
      command(tpdc_pkg::CMD_START, 32'hFFFF_FFFF);        // longest duration waits
      command(tpdc_pkg::CMD_START, 32'd7);
      command(tpdc_pkg::CMD_STOP, 32'd1);                 // keep queue, next run starts
      command(tpdc_pkg::CMD_STOP, 32'd0);                 // flush the queue
      command(tpdc_pkg::CMD_SPEED, 32'd100);
      command(tpdc_pkg::CMD_START, 32'd1);
      issue(tpdc_pkg::ACT_TICK, 8'h00, tpdc_pkg::CMD_START, 32'd0);
      stop_sending();
      wait_for_results();

      // Sender sparse-ish, receiver mostly stalled; pause midway until drained
      send_idle_pct = 36;
      recv_idle_pct = 81;
      configure(8'hFF, 8'h00);
      random_phase(250, 1'b1, 0);

      // Sender mostly idle, receiver moderate
      send_idle_pct = 81;
      recv_idle_pct = 36;
      configure(8'h5A, 8'h81);
      random_phase(250, 1'b0, 0);

      // Full rate on both sides, with one long result-side hold to fill the block
      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(8'($urandom), 8'hFF);
      random_phase(250, 1'b0, 400);

      if (sb.errors == 0) begin
         $display("timed_pump_drive_controller_core_tb OK");
      end else begin
         $display("timed_pump_drive_controller_core_tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
